// ----- rtl/core/pcse_pkg.sv -----
`default_nettype none

package pcse_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  // widths fixed by the request fields
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
  localparam logic [OP_W-1:0] OP_DUMP    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // per-cycle action applied by every cell of the chain
  localparam logic [2:0] CM_HOLD   = 3'd0;
  localparam logic [2:0] CM_INSERT = 3'd1;
  localparam logic [2:0] CM_DELETE = 3'd2;
  localparam logic [2:0] CM_WRITE  = 3'd3;
  localparam logic [2:0] CM_ROTATE = 3'd4;

  typedef struct packed {
    logic [2:0]        mode;
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  last_idx;
    logic [CHAR_W-1:0] char_val;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/pcse_ifs.sv -----
`default_nettype none

interface pcse_in_if;
  logic                      valid;
  logic                      ready;
  logic [pcse_pkg::OP_W-1:0]   opcode;
  logic [pcse_pkg::POS_W-1:0]  position;
  logic [pcse_pkg::CHAR_W-1:0] char_in;

  modport source (output valid, output opcode, output position, output char_in,
                  input ready);
  modport sink (input valid, input opcode, input position, input char_in,
                output ready);
endinterface

interface pcse_out_if;
  logic                      valid;
  logic                      ready;
  logic [pcse_pkg::ST_W-1:0]   status;
  logic [pcse_pkg::CHAR_W-1:0] char_out;
  logic                      char_valid;
  logic [pcse_pkg::CNT_W-1:0]  length;
  logic                      last;

  modport source (output valid, output status, output char_out, output char_valid,
                  output length, output last, input ready);
  modport sink (input valid, input status, input char_out, input char_valid,
                input length, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pcse_cell.sv -----
`default_nettype none

module pcse_cell (
  input  wire logic                        clk,
  input  wire logic [pcse_pkg::IDX_W-1:0]  cell_idx,
  input  wire pcse_pkg::cell_ctrl_t        ctrl,
  input  wire logic [pcse_pkg::CHAR_W-1:0] left_char,
  input  wire logic [pcse_pkg::CHAR_W-1:0] right_char,
  input  wire logic [pcse_pkg::CHAR_W-1:0] head_char,
  output      logic [pcse_pkg::CHAR_W-1:0] data
);
  import pcse_pkg::*;

  logic [CHAR_W-1:0] data_r;
  logic [CHAR_W-1:0] data_nxt;
  logic [POS_W-1:0]  idx_wide;

  assign idx_wide = POS_W'(cell_idx);
  assign data     = data_r;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.mode)
      CM_INSERT: begin
        if (idx_wide > ctrl.pos) begin
          data_nxt = left_char;
        end else if (idx_wide == ctrl.pos) begin
          data_nxt = ctrl.char_val;
        end
      end
      CM_DELETE: begin
        if (idx_wide >= ctrl.pos) begin
          data_nxt = right_char;
        end
      end
      CM_WRITE: begin
        if (idx_wide == ctrl.pos) begin
          data_nxt = ctrl.char_val;
        end
      end
      CM_ROTATE: begin
        // the tail of the stored run wraps around to the head
        if (cell_idx == ctrl.last_idx) begin
          data_nxt = head_char;
        end else begin
          data_nxt = right_char;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/pcse_chain.sv -----
`default_nettype none

module pcse_chain (
  input  wire logic                        clk,
  input  wire pcse_pkg::cell_ctrl_t        ctrl,
  output      logic [pcse_pkg::CHAR_W-1:0] head_char
);
  import pcse_pkg::*;

  logic [CHAR_W-1:0] cell_data [DEPTH];

  assign head_char = cell_data[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CHAR_W-1:0] left_c;
    logic [CHAR_W-1:0] right_c;

    if (i == 0) begin : g_first
      assign left_c = '0;
    end else begin : g_mid_l
      assign left_c = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_c = cell_data[i];
    end else begin : g_mid_r
      assign right_c = cell_data[i+1];
    end

    pcse_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_char  (left_c),
      .right_char (right_c),
      .head_char  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/core/positional_char_sequence_editor.sv -----
`default_nettype none

// channel  dir  payload                                        handshake
// in_ch    in   opcode[2:0] position[6:0] char_in[7:0]          valid/ready
// out_ch   out  status[1:0] char_out[7:0] char_valid length[6:0] last  valid/ready
//
// insert, delete, replace, clear, unknown opcodes and a dump of an empty sequence
// each give a single result in the output register; cells shift or load in parallel.
// a dump of n characters gives n results after the accepting cycle; the chain rotates
// one cell per result while the output is free; requests are held off until the last
// character has gone out.
// a stalled output holds the register and stops rotation; rst_n clears the count.
module positional_char_sequence_editor (
  input wire logic clk,
  input wire logic rst_n,
  pcse_in_if.sink  in_ch,
  pcse_out_if.source out_ch
);
  import pcse_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_cvalid_r, out_cvalid_nxt;
  logic [CNT_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              in_fire;
  logic              full;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CHAR_W-1:0] head_char;
  cell_ctrl_t        ctrl;
  logic [ST_W-1:0]   req_status;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign full         = (count_r == CNT_W'(DEPTH));
  assign cnt_m1       = count_r - CNT_W'(1);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.char_out   = out_char_r;
  assign out_ch.char_valid = out_cvalid_r;
  assign out_ch.length     = out_len_r;
  assign out_ch.last       = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_char_nxt   = out_char_r;
    out_cvalid_nxt = out_cvalid_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    req_status     = ST_DONE;

    ctrl.mode     = CM_HOLD;
    ctrl.pos      = in_ch.position;
    ctrl.last_idx = cnt_m1[IDX_W-1:0];
    ctrl.char_val = in_ch.char_in;

    if (in_fire) begin
      unique case (in_ch.opcode)
        OP_INSERT: begin
          if (in_ch.position > count_r) begin
            req_status = ST_RANGE;
          end else if (full) begin
            req_status = ST_FULL;
          end else begin
            ctrl.mode = CM_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (in_ch.position >= count_r) begin
            req_status = ST_RANGE;
          end else begin
            ctrl.mode = CM_DELETE;
            count_nxt = cnt_m1;
          end
        end
        OP_REPLACE: begin
          if (in_ch.position < count_r) begin
            ctrl.mode = CM_WRITE;
          end else if (in_ch.position > count_r) begin
            req_status = ST_RANGE;
          end else if (full) begin
            req_status = ST_FULL;
          end else begin
            // append at the end of the run
            ctrl.mode = CM_WRITE;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_DUMP: begin
          if (count_r != '0) begin
            state_nxt  = ST_DUMP;
            remain_nxt = count_r;
          end
        end
        OP_CLEAR: count_nxt = '0;
        default:  req_status = ST_DONE;
      endcase

      if (!(in_ch.opcode == OP_DUMP && count_r != '0)) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = req_status;
        out_char_nxt   = '0;
        out_cvalid_nxt = 1'b0;
        out_len_nxt    = count_nxt;
        out_last_nxt   = 1'b1;
      end
    end else if (state_r == ST_DUMP && out_free) begin
      ctrl.mode      = CM_ROTATE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_DONE;
      out_char_nxt   = head_char;
      out_cvalid_nxt = 1'b1;
      out_len_nxt    = count_r;
      out_last_nxt   = (remain_r == CNT_W'(1));
      remain_nxt     = remain_r - CNT_W'(1);
      if (remain_r == CNT_W'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  pcse_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .head_char (head_char)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_char_r   <= out_char_nxt;
    out_cvalid_r <= out_cvalid_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stored count above depth");

  a_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DUMP |-> (remain_r != '0 && remain_r <= count_r))
    else $error("dump counter out of range");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.opcode == OP_INSERT && req_status == ST_DONE)
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the sequence");

  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP && out_free && remain_r == CNT_W'(1))
    |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("dump did not end with a last result");

  a_count_held_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |=> $stable(count_r))
    else $error("count changed during dump");

endmodule

`default_nettype wire
